// ===== design/ecr_pkg.sv =====
package ecr_pkg;

  localparam int MAP_ENTRIES_DEF = 65536;
  localparam int TRACE_DEPTH_DEF = 4096;

  localparam int OP_W      = 2;
  localparam int ID_W      = 16;
  localparam int RADDR_W   = 64;
  localparam int IDX_W     = 16;
  localparam int CNT_W     = 8;
  localparam int VALUE_W   = 64;
  localparam int TCOUNT_W  = 13;
  localparam int DROP_W    = 32;

  // in tdata: block_id, return_address, index, clear_after_read, zero pad
  localparam int IN_DATA_W  = 104;
  // out tdata: read_value, trace_count, dropped_count, zero pad
  localparam int OUT_DATA_W = 112;

  typedef enum logic [OP_W-1:0] {
    OP_BLOCK       = 2'd0,
    OP_READ_CNT    = 2'd1,
    OP_READ_TRACE  = 2'd2,
    OP_START_RUN   = 2'd3
  } op_t;

endpackage

// ===== design/ecr_cov_map.sv =====
module ecr_cov_map #(
  parameter int MAP_ENTRIES = ecr_pkg::MAP_ENTRIES_DEF,
  parameter int MAP_AW      = $clog2(MAP_ENTRIES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [MAP_AW-1:0]         rd_addr,
  output logic [ecr_pkg::CNT_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [MAP_AW-1:0]         wr_addr,
  input  logic [ecr_pkg::CNT_W-1:0] wr_data,
  output logic                      clr_busy
);

  logic [ecr_pkg::CNT_W-1:0] mem [MAP_ENTRIES];
  logic [ecr_pkg::CNT_W-1:0] rd_data_r;
  logic                      clr_busy_r;
  logic [MAP_AW-1:0]         clr_addr_r;

  logic                      mem_we;
  logic [MAP_AW-1:0]         mem_wa;
  logic [ecr_pkg::CNT_W-1:0] mem_wd;

  // zeroing sweep after reset owns the write port
  always_comb begin
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == MAP_AW'(MAP_ENTRIES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== design/edge_coverage_recorder_unit.sv =====
// Edge coverage recorder. Each input transaction is one operation, chosen by in_tuser: a block
// event bumps the 8-bit hit counter at (previous location XOR block id) mod MAP_ENTRIES and,
// when trace_enable is set, appends the return address to the trace store (or counts a drop
// once the store holds TRACE_DEPTH entries); a counter read returns a hit counter and can zero
// it; a trace read returns an entry written in this run, else zero; start run clears the
// previous location, the trace count and the drop count. Every operation gives one result
// transaction with the read value and the trace and drop counts after the operation. One
// operation is in flight at a time: on acceptance a reciprocal multiply gives a registered
// quotient estimate; in the slot state the slot is corrected and the map and trace memories
// are read into registers; in the exec state the map is written back and the free output
// register loaded, so the next operation can enter while a result waits. After reset the map
// is zeroed one entry per cycle, accepting no operation; trace_enable is writable at any time.
module edge_coverage_recorder_unit #(
  parameter int MAP_ENTRIES = ecr_pkg::MAP_ENTRIES_DEF,
  parameter int TRACE_DEPTH = ecr_pkg::TRACE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,     // trace_enable
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // block_id, return_address, index, clear_after_read, zero pad
  input  logic [ecr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [ecr_pkg::OP_W-1:0]       in_tuser,      // operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // read_value, trace_count, dropped_count, zero pad
  output logic [ecr_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int MAP_AW   = $clog2(MAP_ENTRIES);
  localparam int TRACE_AW = $clog2(TRACE_DEPTH);
  localparam int FILL_W   = $clog2(TRACE_DEPTH + 1);
  localparam int RAW_W    = ecr_pkg::ID_W;
  localparam int RECIP_W  = 33 - MAP_AW;
  localparam int PROD_W   = RAW_W + RECIP_W;
  localparam int Q_W      = PROD_W - 32;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / MAP_ENTRIES);
  localparam int PAD_W    = ecr_pkg::OUT_DATA_W - ecr_pkg::VALUE_W - ecr_pkg::TCOUNT_W
                            - ecr_pkg::DROP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_EXEC
  } state_t;

  // input unpacking
  logic [ecr_pkg::ID_W-1:0]    in_block_id;
  logic [ecr_pkg::RADDR_W-1:0] in_ret_addr;
  logic [ecr_pkg::IDX_W-1:0]   in_index;
  logic                        in_clear;
  ecr_pkg::op_t                in_op;

  assign in_block_id = in_tdata[15:0];
  assign in_ret_addr = in_tdata[79:16];
  assign in_index    = in_tdata[95:80];
  assign in_clear    = in_tdata[96];
  assign in_op       = ecr_pkg::op_t'(in_tuser);

  state_t                      state_r;
  ecr_pkg::op_t                op_r;
  logic [ecr_pkg::ID_W-1:0]    id_r;
  logic [ecr_pkg::RADDR_W-1:0] ret_addr_r;
  logic [ecr_pkg::IDX_W-1:0]   idx_r;
  logic                        clear_r;
  logic [RAW_W-1:0]            raw_r;
  logic [Q_W-1:0]              q_r;
  logic [MAP_AW-1:0]           slot_r;
  logic                        trace_hit_r;
  logic [ecr_pkg::RADDR_W-1:0] trace_rd_r;

  logic [ecr_pkg::ID_W-1:0]    prev_r, prev_nxt;
  logic [FILL_W-1:0]           fill_r, fill_nxt;
  logic [ecr_pkg::DROP_W-1:0]  drop_r, drop_nxt;
  logic                        trace_en_r;

  logic                           out_tvalid_r;
  logic [ecr_pkg::OUT_DATA_W-1:0] out_tdata_r;

  logic [ecr_pkg::RADDR_W-1:0] trace_mem [TRACE_DEPTH];

  logic                        in_fire;
  logic                        out_load;
  logic                        clr_busy;
  logic [RAW_W-1:0]            raw_in;
  logic [PROD_W-1:0]           prod;
  logic [RAW_W:0]              rem_est;
  logic [MAP_AW-1:0]           slot;
  logic [ecr_pkg::CNT_W-1:0]   map_rd;
  logic                        map_we;
  logic [ecr_pkg::CNT_W-1:0]   map_wd;
  logic                        trace_we;
  logic [ecr_pkg::VALUE_W-1:0] value;

  assign in_tready = (state_r == S_IDLE) && !clr_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);

  // slot = raw mod MAP_ENTRIES: quotient estimate by reciprocal, then one correction
  assign raw_in  = (in_op == ecr_pkg::OP_BLOCK) ? (prev_r ^ in_block_id) : in_index;
  assign prod    = PROD_W'(raw_in) * PROD_W'(RECIP);
  assign rem_est = (RAW_W + 1)'(raw_r) - (RAW_W + 1)'(q_r * MAP_ENTRIES);
  assign slot    = (rem_est >= (RAW_W + 1)'(MAP_ENTRIES))
                   ? MAP_AW'(rem_est - (RAW_W + 1)'(MAP_ENTRIES))
                   : MAP_AW'(rem_est);

  ecr_cov_map #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .MAP_AW      (MAP_AW)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (state_r == S_SLOT),
    .rd_addr  (slot),
    .rd_data  (map_rd),
    .wr_en    (map_we),
    .wr_addr  (slot_r),
    .wr_data  (map_wd),
    .clr_busy (clr_busy)
  );

  always_comb begin
    prev_nxt = prev_r;
    fill_nxt = fill_r;
    drop_nxt = drop_r;
    map_we   = 1'b0;
    map_wd   = '0;
    trace_we = 1'b0;
    value    = '0;
    unique case (op_r)
      ecr_pkg::OP_BLOCK: begin
        map_we   = out_load;
        map_wd   = map_rd + 1'b1;
        prev_nxt = id_r >> 1;
        if (trace_en_r) begin
          if (fill_r == FILL_W'(TRACE_DEPTH)) begin
            drop_nxt = drop_r + 1'b1;
          end else begin
            trace_we = out_load;
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      ecr_pkg::OP_READ_CNT: begin
        value  = ecr_pkg::VALUE_W'(map_rd);
        map_we = out_load && clear_r;
      end
      ecr_pkg::OP_READ_TRACE: begin
        value = trace_hit_r ? trace_rd_r : '0;
      end
      ecr_pkg::OP_START_RUN: begin
        prev_nxt = '0;
        fill_nxt = '0;
        drop_nxt = '0;
      end
      default: begin
        value = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
      prev_r       <= '0;
      fill_r       <= '0;
      drop_r       <= '0;
      trace_en_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        trace_en_r <= cfg_wdata;
      end
      if (out_tvalid_r && out_tready && !out_load) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_SLOT;
          end
        end
        S_SLOT: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (out_load) begin
            state_r      <= S_IDLE;
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {PAD_W'(0), drop_nxt, ecr_pkg::TCOUNT_W'(fill_nxt), value};
            prev_r       <= prev_nxt;
            fill_r       <= fill_nxt;
            drop_r       <= drop_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // operation payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_op;
      id_r       <= in_block_id;
      ret_addr_r <= in_ret_addr;
      idx_r      <= in_index;
      clear_r    <= in_clear;
      raw_r      <= raw_in;
      q_r        <= prod[PROD_W-1:32];
    end
    if (state_r == S_SLOT) begin
      slot_r      <= slot;
      trace_hit_r <= 32'(idx_r) < 32'(fill_r);
      trace_rd_r  <= trace_mem[TRACE_AW'(idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (trace_we) begin
      trace_mem[fill_r[TRACE_AW-1:0]] <= ret_addr_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready)
    else $error("transaction accepted during map clearing sweep");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= TRACE_DEPTH)
    else $error("trace fill beyond trace depth");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid_r || out_tready))
    else $error("result overwrites a pending output transaction");

  a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(drop_r) |-> (32'($past(fill_r)) == TRACE_DEPTH) || (drop_r == '0))
    else $error("drop count moved while the trace store had room");
`endif

endmodule
